// ----- design/cossim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cossim_pkg
// Shared types and constants for the streaming cosine similarity core.
// ----------------------------------------------------------------------------
package cossim_pkg;

  // Q1.15 output format
  localparam int unsigned COS_W     = 16;
  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned ELEM_W    = 16;

  // quotient of dot^2 * 2^30 / (|A|^2 |B|^2) never exceeds 2^30
  localparam int unsigned QUO_W      = 2 * FRAC_BITS + 1;
  localparam int unsigned DIV_STEPS  = 2 * FRAC_BITS;
  localparam int unsigned ROOT_W     = COS_W;

  localparam logic [COS_W-1:0] COS_POS_MAX = 16'h7fff;
  localparam logic [COS_W-1:0] COS_NEG_MIN = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV0,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } back_state_e;

endpackage

// ----- design/cossim_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cossim_fifo
// Two-entry queue between the accumulating front and the arithmetic back.
// ----------------------------------------------------------------------------
module cossim_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/cossim_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cossim_front
// Accepts element pairs, keeps the dot and norm sums, hands them on at last.
// ----------------------------------------------------------------------------
module cossim_front #(
  parameter int unsigned MAX_LEN      = 128,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned DOT_W        = 39,
  parameter int unsigned NORM_W       = 38
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cossim_pkg::ELEM_W-1:0]       elem_a_i,
  input  logic [cossim_pkg::ELEM_W-1:0]       elem_b_i,
  input  logic                                last_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output logic [DOT_W+2*NORM_W-1:0]           push_data_o
);
  import cossim_pkg::*;

  localparam int unsigned EXT_W = (SAMPLE_WIDTH > ELEM_W) ? SAMPLE_WIDTH : ELEM_W;
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  logic [EXT_W-1:0]                a_ext, b_ext;
  logic signed [SAMPLE_WIDTH-1:0]  a_s, b_s;
  logic signed [2*SAMPLE_WIDTH-1:0] pab, paa, pbb;
  logic signed [DOT_W-1:0]         dot_q, dot_d, dot_n;
  logic [NORM_W-1:0]               na_q, na_d, na_n;
  logic [NORM_W-1:0]               nb_q, nb_d, nb_n;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic                            en, acc;

  // only the low SAMPLE_WIDTH bits count, as two's complement
  assign a_ext = EXT_W'(elem_a_i);
  assign b_ext = EXT_W'(elem_b_i);
  assign a_s   = a_ext[SAMPLE_WIDTH-1:0];
  assign b_s   = b_ext[SAMPLE_WIDTH-1:0];
  assign pab   = a_s * b_s;
  assign paa   = a_s * a_s;
  assign pbb   = b_s * b_s;

  assign en    = (cnt_q < CNT_W'(MAX_LEN));
  assign dot_n = en ? dot_q + DOT_W'(pab) : dot_q;
  assign na_n  = en ? na_q + NORM_W'($unsigned(paa)) : na_q;
  assign nb_n  = en ? nb_q + NORM_W'($unsigned(pbb)) : nb_q;

  assign in_ready_o   = push_ready_i;
  assign acc          = in_valid_i && in_ready_o;
  assign push_valid_o = acc && last_i;
  assign push_data_o  = {nb_n, na_n, dot_n};

  always_comb begin
    dot_d = dot_q;
    na_d  = na_q;
    nb_d  = nb_q;
    cnt_d = cnt_q;
    if (acc) begin
      if (last_i) begin
        dot_d = '0;
        na_d  = '0;
        nb_d  = '0;
        cnt_d = '0;
      end else begin
        dot_d = dot_n;
        na_d  = na_n;
        nb_d  = nb_n;
        cnt_d = en ? cnt_q + CNT_W'(1) : cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      cnt_q <= '0;
    end else begin
      dot_q <= dot_d;
      na_q  <= na_d;
      nb_q  <= nb_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/cossim_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cossim_back
// Serial multiply, restoring divide and integer root giving the Q1.15 cosine.
// ----------------------------------------------------------------------------
module cossim_back #(
  parameter int unsigned DOT_W  = 39,
  parameter int unsigned NORM_W = 38
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  logic [DOT_W+2*NORM_W-1:0]         pop_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cossim_pkg::COS_W-1:0]      out_cos_o,
  output logic                              out_zero_o
);
  import cossim_pkg::*;

  localparam int unsigned WW      = 2 * DOT_W + 1;
  localparam int unsigned CNT_MAX = (DOT_W > DIV_STEPS) ? DOT_W : DIV_STEPS;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);
  localparam int unsigned BP_W    = $clog2(ROOT_W);
  localparam int unsigned SQ_W    = 2 * ROOT_W;

  back_state_e           st_q, st_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [WW-1:0]         p_q, p_d, m_q, m_d, pa_q, pa_d, ma_q, ma_d;
  logic [NORM_W-1:0]     pb_q, pb_d;
  logic [DOT_W-1:0]      mb_q, mb_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic                  neg_q, neg_d, zero_q, zero_d;
  logic                  ovld_q, ovld_d, ozero_q, ozero_d;
  logic [COS_W-1:0]      ocos_q, ocos_d;

  logic signed [DOT_W-1:0] in_dot;
  logic [NORM_W-1:0]     in_na, in_nb;
  logic [DOT_W-1:0]      in_mag;
  logic [WW-1:0]         rem2;
  logic                  ge0, ge;
  logic [BP_W-1:0]       bitpos;
  logic [ROOT_W-1:0]     trial;
  logic [SQ_W-1:0]       trial_sq;
  logic [COS_W-1:0]      cos_val;
  logic                  load_out;

  assign in_dot = pop_data_i[DOT_W-1:0];
  assign in_na  = pop_data_i[DOT_W +: NORM_W];
  assign in_nb  = pop_data_i[DOT_W+NORM_W +: NORM_W];
  assign in_mag = in_dot[DOT_W-1] ? DOT_W'(-in_dot) : DOT_W'(in_dot);

  assign ge0      = (m_q >= p_q);
  assign rem2     = {m_q[WW-2:0], 1'b0};
  assign ge       = (rem2 >= p_q);
  assign bitpos   = BP_W'(ROOT_W - 1) - cnt_q[BP_W-1:0];
  assign trial    = root_q | (ROOT_W'(1) << bitpos);
  assign trial_sq = trial * trial;

  // magnitude never exceeds 2^15; the single positive overflow is +1.0
  always_comb begin
    if (zero_q) begin
      cos_val = '0;
    end else if (neg_q) begin
      cos_val = root_q[ROOT_W-1] ? COS_NEG_MIN : COS_W'(-root_q);
    end else begin
      cos_val = root_q[ROOT_W-1] ? COS_POS_MAX : COS_W'(root_q);
    end
  end

  assign pop_ready_o = (st_q == ST_IDLE);
  assign load_out    = (st_q == ST_DONE) && (!ovld_q || out_ready_i);

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    p_d    = p_q;
    m_d    = m_q;
    pa_d   = pa_q;
    pb_d   = pb_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    quo_d  = quo_q;
    root_d = root_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    case (st_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          neg_d  = in_dot[DOT_W-1];
          root_d = '0;
          cnt_d  = '0;
          if (in_na == '0 || in_nb == '0) begin
            zero_d = 1'b1;
            st_d   = ST_DONE;
          end else begin
            zero_d = 1'b0;
            p_d    = '0;
            m_d    = '0;
            pa_d   = WW'(in_na);
            pb_d   = in_nb;
            ma_d   = WW'(in_mag);
            mb_d   = in_mag;
            st_d   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (pb_q[0]) p_d = p_q + pa_q;
        if (mb_q[0]) m_d = m_q + ma_q;
        pa_d  = {pa_q[WW-2:0], 1'b0};
        ma_d  = {ma_q[WW-2:0], 1'b0};
        pb_d  = pb_q >> 1;
        mb_d  = mb_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DOT_W - 1)) begin
          st_d = ST_DIV0;
        end
      end
      ST_DIV0: begin
        // integer part of dot^2 / (|A|^2 |B|^2) is 0 or 1
        m_d   = ge0 ? m_q - p_q : m_q;
        quo_d = QUO_W'(ge0);
        cnt_d = '0;
        st_d  = ST_DIV;
      end
      ST_DIV: begin
        m_d   = ge ? rem2 - p_q : rem2;
        quo_d = {quo_q[QUO_W-2:0], ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d = '0;
          st_d  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (trial_sq <= SQ_W'(quo_q)) root_d = trial;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_d  = ovld_q;
    ocos_d  = ocos_q;
    ozero_d = ozero_q;
    if (load_out) begin
      ovld_d  = 1'b1;
      ocos_d  = cos_val;
      ozero_d = zero_q;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    m_q     <= m_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    quo_q   <= quo_d;
    root_q  <= root_d;
    neg_q   <= neg_d;
    zero_q  <= zero_d;
    ocos_q  <= ocos_d;
    ozero_q <= ozero_d;
  end

  assign out_valid_o = ovld_q;
  assign out_cos_o   = ocos_q;
  assign out_zero_o  = ozero_q;

endmodule

// ----- design/cosine_similarity_stream_core.sv -----
`timescale 1ns / 1ps
// Throughput: one element word per cycle at the input while the queue has room.
// Each finished set of sums passes through the bit-serial multiplier, restoring
// divider and root unit in the back part.
// The input stalls once the two-entry queue fills; the back takes one set at a time.
// Reset (rst_ni low, asynchronous) clears all sums, the queue and the output valid.
// ----------------------------------------------------------------------------
// cosine_similarity_stream_core
// Streaming cosine similarity of two integer vectors, result in Q1.15.
// ----------------------------------------------------------------------------
module cosine_similarity_stream_core #(
  parameter int unsigned MAX_LEN      = 128,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] elem_a, [31:16] elem_b
  input  logic        s_axis_tlast_i,   // last_element
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] cosine
  output logic        m_axis_tuser_o    // [0] zero_norm
);
  import cossim_pkg::*;

  // Sum widths: a product of two samples needs 2*SW bits signed; MAX_LEN of
  // them add clog2(MAX_LEN) bits. Squares are never negative, one bit less.
  localparam int unsigned DOT_W  = 2 * SAMPLE_WIDTH + $clog2(MAX_LEN);
  localparam int unsigned NORM_W = 2 * SAMPLE_WIDTH + $clog2(MAX_LEN) - 1;
  localparam int unsigned Q_W    = DOT_W + 2 * NORM_W;

  logic           q_push_valid, q_push_ready;
  logic [Q_W-1:0] q_push_data;
  logic           q_pop_valid, q_pop_ready;
  logic [Q_W-1:0] q_pop_data;

  // Front: one word a cycle into the sums while the queue has room. On the last
  // word the finished sums (this word included) go into the queue; sums clear.
  cossim_front #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DOT_W        (DOT_W),
    .NORM_W       (NORM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .elem_a_i     (s_axis_tdata_i[15:0]),
    .elem_b_i     (s_axis_tdata_i[31:16]),
    .last_i       (s_axis_tlast_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  // Two sets of sums may wait while the back part is busy.
  cossim_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  // Back: |A|^2|B|^2 and dot^2 by shift-and-add, then dot^2*2^30 divided
  // by the norm product, then the integer root of that quotient. The output
  // word register frees the back part once the result is loaded into it.
  cossim_back #(
    .DOT_W  (DOT_W),
    .NORM_W (NORM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_cos_o   (m_axis_tdata_o),
    .out_zero_o  (m_axis_tuser_o)
  );

  // A vector pair with a zero norm always reports a cosine of zero.
  a_zero_cos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("zero_norm word carries non-zero cosine");

  // Every accepted last word hands its sums to the queue in the same cycle.
  a_last_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |-> q_push_valid)
    else $error("last word did not reach the queue");

  // The queue is never written while full.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_valid |-> q_push_ready)
    else $error("queue push while full");

endmodule

// ----- dv/tb_cosine_similarity_stream_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cosine_similarity_stream_core
// Stream testbench for the cosine similarity core. A queue of element words
// feeds a clocked driver. A bit-exact predictor computes the expected cosine
// and zero-norm flag on each last word. A monitor checks every result word.
// ----------------------------------------------------------------------------
module tb_cosine_similarity_stream_core;

  localparam int unsigned MAX_LEN  = 128;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LATENCY  = 200;

  typedef struct packed {
    logic        last;
    logic [15:0] b;
    logic [15:0] a;
  } elem_word_t;

  typedef struct packed {
    logic        zero_norm;
    logic [15:0] cosine;
  } cos_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_user;

  elem_word_t  pending_q[$];
  cos_word_t   cos_expect_q[$];
  int          n_errors = 0;
  bit          stim_done = 0;

  // running sums of the predictor
  logic signed [63:0] dot_acc, na_acc, nb_acc;
  int unsigned        elem_cnt;

  always #4 clk_i = ~clk_i;

  cosine_similarity_stream_core #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // accumulate one word and, on the last one, queue the expected cosine
  task automatic predict_cosine(input elem_word_t w);
    logic signed [63:0] ea, eb;
    logic [63:0]        mag;
    logic [191:0]       num, den, lhs;
    logic [31:0]        q, t;
    logic signed [31:0] val;
    cos_word_t          r;
    ea = 64'(signed'(w.a[SAMPLE_W-1:0]));
    eb = 64'(signed'(w.b[SAMPLE_W-1:0]));
    if (elem_cnt < MAX_LEN) begin
      dot_acc += ea * eb;
      na_acc  += ea * ea;
      nb_acc  += eb * eb;
      elem_cnt++;
    end
    if (!w.last) return;
    if (na_acc == 0 || nb_acc == 0) begin
      r.cosine    = '0;
      r.zero_norm = 1'b1;
    end else begin
      mag = dot_acc < 0 ? 64'(-dot_acc) : 64'(dot_acc);
      num = (192'(mag) * 192'(mag)) << 30;
      den = 192'(na_acc) * 192'(nb_acc);
      q = 0;
      for (int i = 15; i >= 0; i--) begin
        t   = q | (32'd1 << i);
        lhs = 192'(t) * 192'(t) * den;
        if (lhs <= num) q = t;
      end
      val = dot_acc < 0 ? -$signed(q) : $signed(q);
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      r.cosine    = val[15:0];
      r.zero_norm = 1'b0;
    end
    cos_expect_q.push_back(r);
    dot_acc = 0; na_acc = 0; nb_acc = 0; elem_cnt = 0;
  endtask

  // driver: gaps between words, prediction at acceptance
  int unsigned drv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) predict_cosine(elem_word_t'({s_last, s_data}));
      if (!(s_valid && !s_ready)) begin
        if (drv_gap > 0 || pending_q.size() == 0) begin
          s_valid <= 1'b0;
          if (drv_gap > 0) drv_gap--;
        end else begin
          elem_word_t w;
          w = pending_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= {w.b, w.a};
          s_last  <= w.last;
          drv_gap = gap_len();
        end
      end
    end
  end

  // monitor: random back-pressure, compare against the oldest expectation
  int unsigned stall = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (cos_expect_q.size() == 0) begin
          $error("result word with nothing expected: cosine %0h", m_data);
          n_errors++;
        end else begin
          cos_word_t e;
          e = cos_expect_q.pop_front();
          if (m_data !== e.cosine) begin
            $error("cosine: expected %0d, got %0d", $signed(e.cosine), $signed(m_data));
            n_errors++;
          end
          if (m_user !== e.zero_norm) begin
            $error("zero_norm: expected %0b, got %0b", e.zero_norm, m_user);
            n_errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  function automatic logic [15:0] rnd_elem(input int unsigned mode);
    case (mode)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(signed'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_vec(input int unsigned len, input int unsigned mode);
    elem_word_t w;
    logic [15:0] a;
    logic        rel;
    rel = $urandom_range(0, 3) == 0;   // correlated vectors: b = +/- a
    for (int i = 0; i < len; i++) begin
      a   = rnd_elem($urandom_range(0, 9) < 2 ? mode : 3);
      w.a = a;
      w.b = rel ? (($urandom & 1) ? -a : a) : rnd_elem($urandom_range(0, 9) < 2 ? mode : 3);
      if (mode == 4) w.b = '0;
      w.last = (i == len - 1);
      pending_q.push_back(w);
    end
  endtask

  initial begin
    int unsigned n;
    dot_acc = 0; na_acc = 0; nb_acc = 0; elem_cnt = 0;
    // directed: extremes, exact +1 and -1, zero norms, single element
    pending_q.push_back('{1'b1, 16'h7fff, 16'h7fff});
    pending_q.push_back('{1'b1, 16'h8000, 16'h8000});
    pending_q.push_back('{1'b1, 16'h7fff, 16'h8000});
    pending_q.push_back('{1'b1, 16'h8000, 16'h7fff});
    pending_q.push_back('{1'b1, 16'h0000, 16'h0000});
    pending_q.push_back('{1'b1, 16'h0005, 16'h0000});
    pending_q.push_back('{1'b1, 16'h0000, 16'hfff3});
    pending_q.push_back('{1'b0, 16'h0003, 16'h0004});
    pending_q.push_back('{1'b1, 16'hfffd, 16'h0004});
    pending_q.push_back('{1'b0, 16'h0001, 16'h0001});
    pending_q.push_back('{1'b1, 16'h0001, 16'hffff});
    pending_q.push_back('{1'b0, 16'h5555, 16'haaaa});
    pending_q.push_back('{1'b1, 16'haaaa, 16'h5555});
    for (int i = 0; i < 10; i++) pending_q.push_back('{i == 9, 16'h8000, 16'h8000});
    // two overlong vectors past MAX_LEN, both with large elements mixed in
    push_vec(MAX_LEN + 20, 1);
    push_vec(MAX_LEN + 3, 0);
    n = 0;
    while (n < 1650) begin
      int unsigned len, mode;
      len  = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6);
      mode = $urandom_range(0, 4);
      push_vec(len, mode);
      n += len;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !s_valid);
    wait (cos_expect_q.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
    if (n_errors == 0 && cos_expect_q.size() == 0) begin
      $display("tb_cosine_similarity_stream_core: done, clean");
    end else begin
      $display("tb_cosine_similarity_stream_core: done, errors");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("tb_cosine_similarity_stream_core: done, errors");
    $finish;
  end

endmodule

// ----- cosine_similarity_stream_core.f -----
design/cossim_pkg.sv
design/cossim_fifo.sv
design/cossim_front.sv
design/cossim_back.sv
design/cosine_similarity_stream_core.sv
dv/tb_cosine_similarity_stream_core.sv
